[rtl/yuv444_to_yuv420_subsampler_defines.svh]
// Assertion helpers shared by the subsampler RTL.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef YUV444_TO_YUV420_SUBSAMPLER_DEFINES_SVH
`define YUV444_TO_YUV420_SUBSAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define YUVSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define YUVSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/yuvss_pkg.sv]
package yuvss_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_W         = 13;
  // Wide enough for a 13-bit size and for the largest line-length limit.
  localparam int SIZE_W        = 15;
  localparam int ROW_W         = 12;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // A pixel as the front end classified it.
  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic             col_odd;
    logic             row_odd;
    logic             frame_end;
  } pix_tag_t;

  // Even size of at least two, clipped to the limit.
  function automatic logic [SIZE_W-1:0] effective_size(input logic [CFG_W-1:0] raw,
                                                       input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] s;
    s = SIZE_W'({raw[CFG_W-1:1], 1'b0});
    if (s < SIZE_W'(2)) s = SIZE_W'(2);
    if (s > limit) s = limit & ~SIZE_W'(1);
    return s;
  endfunction

endpackage

[rtl/yuvss_channels.sv]
interface yuvss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] y_in;
  logic [7:0] u_in;
  logic [7:0] v_in;

  modport source (output valid, y_in, u_in, v_in, input ready);
  modport sink   (input valid, y_in, u_in, v_in, output ready);
endinterface

interface yuvss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out;
  logic       chroma_valid;
  logic [7:0] u_out;
  logic [7:0] v_out;
  logic       frame_end;

  modport source (output valid, luma_out, chroma_valid, u_out, v_out, frame_end,
                  input ready);
  modport sink   (input valid, luma_out, chroma_valid, u_out, v_out, frame_end,
                  output ready);
endinterface

[rtl/yuvss_ram.sv]
module yuvss_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/yuvss_queue.sv]
module yuvss_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

[rtl/yuvss_front.sv]
module yuvss_front import yuvss_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
  localparam int SLOT_W = (COL_W > 1) ? COL_W - 1 : 1
) (
  input  logic              clk,
  input  logic              rst,
  yuvss_in_if.sink          pix_in,
  input  logic [CFG_W-1:0]  frame_width,
  input  logic [CFG_W-1:0]  frame_height,
  output logic              push_valid,
  input  logic              push_ready,
  output pix_tag_t          tag,
  output logic [SLOT_W-1:0] slot
);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic              last_col;
  logic              last_row;
  logic              accept;

  assign w_eff    = effective_size(frame_width, SIZE_W'(MAX_WIDTH));
  assign h_eff    = effective_size(frame_height, SIZE_W'(MAX_HEIGHT));
  assign last_col = (SIZE_W'(col) + SIZE_W'(1)) >= w_eff;
  assign last_row = (SIZE_W'(row) + SIZE_W'(1)) >= h_eff;

  assign pix_in.ready = push_ready;
  assign push_valid   = pix_in.valid;
  assign accept       = pix_in.valid && push_ready;

  always_comb begin
    tag.y         = pix_in.y_in;
    tag.u         = pix_in.u_in;
    tag.v         = pix_in.v_in;
    tag.col_odd   = col[0];
    tag.row_odd   = row[0];
    tag.frame_end = last_col && last_row;
    slot          = SLOT_W'(col >> 1);
  end

  always_comb begin
    col_next = col + COL_W'(1);
    row_next = row;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

[rtl/yuvss_back.sv]
module yuvss_back import yuvss_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
  localparam int SLOT_W = (COL_W > 1) ? COL_W - 1 : 1,
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  pix_tag_t          q_tag,
  input  logic [SLOT_W-1:0] q_slot,
  output logic              q_pop,
  yuvss_out_if.source       pix_out
);

  localparam int PAIR_W = PIX_W + 1;
  localparam int SUM_W  = PIX_W + 2;

  logic [PIX_W-1:0]    held_u;
  logic [PIX_W-1:0]    held_v;
  logic [PAIR_W-1:0]   pair_u;
  logic [PAIR_W-1:0]   pair_v;
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [2*PAIR_W-1:0] ram_rd_data;

  logic                r_valid;
  logic [PIX_W-1:0]    r_y;
  logic                r_cv;
  logic                r_fend;
  logic [PAIR_W-1:0]   r_pair_u;
  logic [PAIR_W-1:0]   r_pair_v;
  logic                r_adv;
  logic [SUM_W-1:0]    sum_u;
  logic [SUM_W-1:0]    sum_v;

  logic                out_valid;
  logic [PIX_W-1:0]    out_y;
  logic                out_cv;
  logic [PIX_W-1:0]    out_u;
  logic [PIX_W-1:0]    out_v;
  logic                out_fend;

  assign pair_u = {1'b0, held_u} + {1'b0, q_tag.u};
  assign pair_v = {1'b0, held_v} + {1'b0, q_tag.v};

  assign r_adv = r_valid && (!out_valid || pix_out.ready);
  assign q_pop = q_valid && (!r_valid || r_adv);

  // Even rows store the pair sums; odd rows fetch them for the same slot.
  assign ram_wr_en = q_pop && q_tag.col_odd && !q_tag.row_odd;
  assign ram_rd_en = q_pop && q_tag.row_odd;

  yuvss_ram #(
    .WIDTH (2 * PAIR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (q_slot),
    .wr_data ({pair_u, pair_v}),
    .rd_en   (ram_rd_en),
    .rd_addr (q_slot),
    .rd_data (ram_rd_data)
  );

  assign sum_u = {1'b0, ram_rd_data[2*PAIR_W-1:PAIR_W]} + {1'b0, r_pair_u} + SUM_W'(2);
  assign sum_v = {1'b0, ram_rd_data[PAIR_W-1:0]} + {1'b0, r_pair_v} + SUM_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_u <= '0;
      held_v <= '0;
    end else if (q_pop && !q_tag.col_odd) begin
      held_u <= q_tag.u;
      held_v <= q_tag.v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (q_pop) begin
      r_valid <= 1'b1;
    end else if (r_adv) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r_y      <= q_tag.y;
      r_cv     <= q_tag.col_odd && q_tag.row_odd;
      r_fend   <= q_tag.frame_end;
      r_pair_u <= pair_u;
      r_pair_v <= pair_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_adv) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      out_y    <= r_y;
      out_cv   <= r_cv;
      out_fend <= r_fend;
      out_u    <= r_cv ? sum_u[SUM_W-1:2] : '0;
      out_v    <= r_cv ? sum_v[SUM_W-1:2] : '0;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.luma_out     = out_y;
  assign pix_out.chroma_valid = out_cv;
  assign pix_out.u_out        = out_u;
  assign pix_out.v_out        = out_v;
  assign pix_out.frame_end    = out_fend;

endmodule

[rtl/yuv444_to_yuv420_subsampler.sv]
// YUV 4:4:4 to 4:2:0 chroma subsampler.
// pix_in carries one packed pixel (y_in, u_in, v_in) per transfer in raster order.
// pix_out returns one result per pixel: the luma byte unchanged, and on the
// odd-column pixel of each odd row the rounded 2x2 mean of U and V with
// chroma_valid set; u_out and v_out read zero on every other result.
// frame_end marks the last pixel of the configured frame.
// The APB port holds frame_width (byte address 0) and frame_height (address 4);
// only paddr[2] selects the register. Sizes are rounded down to even, at least 2,
// and width is clipped to MAX_WIDTH, height to 4096. Write them only while idle.
// Throughput is one pixel per clock while pix_out.ready stays high. Each pixel passes
// through the classification queue, the line-store read stage and the output register.
// The line store is a single-port-write, registered-read RAM of MAX_WIDTH/2 entries,
// each holding the U and V pair sums of one column pair of an even row.
// When the receiver stalls, the output register, the read stage and a four-entry
// queue fill before pix_in.ready drops, so up to six pixels are absorbed.
// Reset (synchronous, active high) returns both sizes to 640x480, clears the pixel
// position to the top-left corner and empties the pipeline; the line store is not
// cleared, as every entry is written on an even row before an odd row reads it.
`include "yuv444_to_yuv420_subsampler_defines.svh"

module yuv444_to_yuv420_subsampler import yuvss_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  yuvss_in_if.sink    pix_in,
  yuvss_out_if.source pix_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int SLOT_W = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int TAG_W  = $bits(pix_tag_t);
  localparam int Q_W    = TAG_W + SLOT_W;

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  reg_idx_t          reg_sel;

  logic              f_valid;
  logic              f_ready;
  pix_tag_t          f_tag;
  logic [SLOT_W-1:0] f_slot;

  logic              q_valid;
  logic              q_pop;
  logic [Q_W-1:0]    q_data;
  pix_tag_t          q_tag;
  logic [SLOT_W-1:0] q_slot;

  // Configuration registers. The low address bits act as byte lanes and are ignored.
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(RESET_WIDTH);
      frame_height <= CFG_W'(RESET_HEIGHT);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Front end: tracks the raster position and tags each pixel with its role.
  yuvss_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pix_in       (pix_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .push_valid   (f_valid),
    .push_ready   (f_ready),
    .tag          (f_tag),
    .slot         (f_slot)
  );

  // Short queue that lets the front end keep taking pixels while the output stalls.
  yuvss_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_slot, f_tag}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign q_tag  = pix_tag_t'(q_data[TAG_W-1:0]);
  assign q_slot = q_data[Q_W-1:TAG_W];

  // Back end: line store access, averaging and the output register.
  yuvss_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_tag   (q_tag),
    .q_slot  (q_slot),
    .q_pop   (q_pop),
    .pix_out (pix_out)
  );

  // Chroma fields are forced to zero on results that do not complete a block.
  `YUVSS_ASSERT_NOW(a_chroma_zero, pix_out.valid && !pix_out.chroma_valid, (pix_out.u_out == '0) && (pix_out.v_out == '0), "chroma nonzero on a result without a block")
  // The back end never pops an empty queue.
  `YUVSS_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")
  // A pixel taken without a simultaneous pop is waiting in the queue next cycle.
  `YUVSS_ASSERT_NEXT(a_push_visible, pix_in.valid && pix_in.ready && !q_pop, q_valid, "accepted pixel missing from queue")

endmodule
